// ----- rtl/core/pwih_pkg.sv -----
// pwih_pkg: types, constants and helpers of the polygon wall inside and hit block
// depends on nothing; imported by every module under rtl/core
package pwih_pkg;

   localparam int MAX_VERTICES = 256;
   localparam int COORD_WIDTH  = 24;
   localparam int FIELD_W      = 24;
   localparam int ADDR_W       = $clog2(MAX_VERTICES);
   localparam int CNT_W        = ADDR_W + 1;
   localparam int DIFF_W       = COORD_WIDTH + 1;
   localparam int PROD_W       = 2 * DIFF_W;
   localparam int SUM_W        = 2 * DIFF_W + 2;
   localparam int REM_W        = SUM_W + 1;
   localparam int FRAC_BITS    = 16;
   localparam int QUO_W        = FRAC_BITS + 1;
   localparam int STEP_W       = $clog2(FRAC_BITS + 1);

   localparam logic [17:0] FRAC_NONE = 18'd131072;

   localparam logic ACT_LOAD  = 1'b0;
   localparam logic ACT_QUERY = 1'b1;

   typedef logic signed [COORD_WIDTH-1:0] coord_type;
   typedef logic signed [DIFF_W-1:0]      diff_type;
   typedef logic signed [PROD_W-1:0]      prod_type;
   typedef logic signed [SUM_W-1:0]       sum_type;
   typedef logic [ADDR_W-1:0]             addr_type;

   typedef struct packed {
      logic                      action;
      logic [7:0]                vertex_index;
      logic signed [FIELD_W-1:0] vertex_r;
      logic signed [FIELD_W-1:0] vertex_z;
      logic signed [FIELD_W-1:0] start_r;
      logic signed [FIELD_W-1:0] start_z;
      logic signed [FIELD_W-1:0] end_r;
      logic signed [FIELD_W-1:0] end_z;
   } req_type;

   typedef struct packed {
      logic        point_inside;
      logic [8:0]  hit_edge;
      logic [17:0] hit_fraction;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_FETCH,
      ST_DIFF,
      ST_MUL,
      ST_SUM,
      ST_EVAL,
      ST_DIV,
      ST_UPDATE,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic     load_we;
      logic     start;
      logic     fetch;
      logic     diff;
      logic     mul;
      logic     sum;
      logic     eval;
      logic     div_load;
      logic     div_step;
      logic     update;
      logic     out_load;
      addr_type edge_addr;
      addr_type next_addr;
   } cmd_type;

   typedef struct packed {
      logic hit;
      logic rsp_hold;
   } sts_type;

   // raw field bits taken as a coordinate of COORD_WIDTH bits
   function automatic coord_type to_coord(input logic [FIELD_W-1:0] raw);
      return coord_type'(COORD_WIDTH'(raw));
   endfunction

endpackage

// ----- rtl/core/pwih_ctrl.sv -----
// pwih_ctrl: sequencer over the polygon edges, csr register and input handshake
// depends on pwih_pkg
module pwih_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic             req_action,
   input  logic [7:0]       req_index,
   input  logic             csr_valid,
   input  logic [8:0]       csr_data,
   input  pwih_pkg::sts_type sts,
   output pwih_pkg::cmd_type cmd
);
   import pwih_pkg::*;

   state_type         state_ff, state_in;
   addr_type          edge_ff, edge_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [8:0]        count_ff;
   logic [CNT_W-1:0]  n_edges;
   logic [CNT_W-1:0]  edge_p1;
   logic              last_edge;
   logic              accept;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         edge_ff  <= '0;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         edge_ff  <= edge_in;
         step_ff  <= step_in;
         if (csr_valid) begin
            count_ff <= csr_data;
         end
      end
   end

   always_comb begin
      if (32'(count_ff) > MAX_VERTICES) begin
         n_edges = CNT_W'(MAX_VERTICES);
      end else begin
         n_edges = CNT_W'(count_ff);
      end
      edge_p1   = {1'b0, edge_ff} + CNT_W'(1);
      last_edge = (edge_p1 == n_edges);
   end

   always_comb begin
      state_in      = state_ff;
      edge_in       = edge_ff;
      step_in       = step_ff;
      cmd           = '0;
      cmd.edge_addr = edge_ff;
      cmd.next_addr = last_edge ? '0 : edge_p1[ADDR_W-1:0];
      req_ready     = (state_ff == ST_IDLE);
      accept        = req_valid && req_ready;
      case (state_ff)
         ST_IDLE: begin
            if (accept && req_action == ACT_LOAD) begin
               cmd.load_we = (32'(req_index) < MAX_VERTICES);
            end
            if (accept && req_action == ACT_QUERY) begin
               cmd.start = 1'b1;
               edge_in   = '0;
               state_in  = (n_edges == '0) ? ST_DONE : ST_FETCH;
            end
         end
         ST_FETCH: begin
            cmd.fetch = 1'b1;
            state_in  = ST_DIFF;
         end
         ST_DIFF: begin
            cmd.diff = 1'b1;
            state_in = ST_MUL;
         end
         ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = ST_SUM;
         end
         ST_SUM: begin
            cmd.sum  = 1'b1;
            state_in = ST_EVAL;
         end
         ST_EVAL: begin
            cmd.eval = 1'b1;
            if (sts.hit) begin
               cmd.div_load = 1'b1;
               step_in      = '0;
               state_in     = ST_DIV;
            end else if (last_edge) begin
               state_in = ST_DONE;
            end else begin
               edge_in  = edge_p1[ADDR_W-1:0];
               state_in = ST_FETCH;
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            step_in      = step_ff + STEP_W'(1);
            if (step_ff == STEP_W'(FRAC_BITS - 1)) begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            cmd.update = 1'b1;
            if (last_edge) begin
               state_in = ST_DONE;
            end else begin
               edge_in  = edge_p1[ADDR_W-1:0];
               state_in = ST_FETCH;
            end
         end
         ST_DONE: begin
            if (!sts.rsp_hold) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// ----- rtl/core/pwih_datapath.sv -----
// pwih_datapath: vertex stores, edge arithmetic, fraction divider and result register
// depends on pwih_pkg; driven by pwih_ctrl commands
module pwih_datapath (
   input  logic              clock,
   input  logic              reset,
   input  pwih_pkg::cmd_type cmd,
   output pwih_pkg::sts_type sts,
   input  pwih_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output pwih_pkg::rsp_type rsp_data
);
   import pwih_pkg::*;

   coord_type mem_r [MAX_VERTICES];
   coord_type mem_z [MAX_VERTICES];

   coord_type r3_ff, z3_ff, r4_ff, z4_ff;
   coord_type pr_ff, pz_ff;
   diff_type  qr_ff, qz_ff;
   diff_type  wr1_ff, wz1_ff, wr2_ff, wz2_ff, dr_ff, dz_ff;
   prod_type  p_num_a_ff, p_num_b_ff, p_den_a_ff, p_den_b_ff;
   prod_type  p_nt_a_ff, p_nt_b_ff, p_nu_a_ff, p_nu_b_ff;
   sum_type   num_ff, den_ff, nt_ff, nu_ff;

   logic [SUM_W-1:0] dvs_ff;
   logic [REM_W-1:0] rem_ff;
   logic [QUO_W-1:0] quo_ff;

   logic              parity_ff;
   logic [8:0]        best_edge_ff;
   logic [17:0]       best_frac_ff;
   logic              rsp_valid_ff;
   rsp_type           rsp_ff;

   coord_type         sr, sz, er, ez;
   sum_type           den_abs, nt_adj, nu_adj;
   logic              hit;
   logic              crossing;
   logic [REM_W-1:0]  rem_sh, rem_init;

   assign sr = to_coord(req_data.start_r);
   assign sz = to_coord(req_data.start_z);
   assign er = to_coord(req_data.end_r);
   assign ez = to_coord(req_data.end_z);

   // vertex stores, two registered read ports for both ends of an edge
   always_ff @(posedge clock) begin
      if (cmd.load_we) begin
         mem_r[ADDR_W'(req_data.vertex_index)] <= to_coord(req_data.vertex_r);
         mem_z[ADDR_W'(req_data.vertex_index)] <= to_coord(req_data.vertex_z);
      end
      if (cmd.fetch) begin
         r3_ff <= mem_r[cmd.edge_addr];
         z3_ff <= mem_z[cmd.edge_addr];
         r4_ff <= mem_r[cmd.next_addr];
         z4_ff <= mem_z[cmd.next_addr];
      end
   end

   // edge arithmetic stages
   always_ff @(posedge clock) begin
      if (cmd.start) begin
         pr_ff <= sr;
         pz_ff <= sz;
         qr_ff <= diff_type'(sr) - diff_type'(er);
         qz_ff <= diff_type'(sz) - diff_type'(ez);
      end
      if (cmd.diff) begin
         wr1_ff <= diff_type'(r3_ff) - diff_type'(pr_ff);
         wz1_ff <= diff_type'(z3_ff) - diff_type'(pz_ff);
         wr2_ff <= diff_type'(r4_ff) - diff_type'(pr_ff);
         wz2_ff <= diff_type'(z4_ff) - diff_type'(pz_ff);
         dr_ff  <= diff_type'(r3_ff) - diff_type'(r4_ff);
         dz_ff  <= diff_type'(z3_ff) - diff_type'(z4_ff);
      end
      if (cmd.mul) begin
         p_num_a_ff <= wz1_ff * wr2_ff;
         p_num_b_ff <= wr1_ff * wz2_ff;
         p_den_a_ff <= qr_ff * dz_ff;
         p_den_b_ff <= qz_ff * dr_ff;
         p_nt_a_ff  <= wz1_ff * dr_ff;
         p_nt_b_ff  <= wr1_ff * dz_ff;
         p_nu_a_ff  <= wz1_ff * qr_ff;
         p_nu_b_ff  <= wr1_ff * qz_ff;
      end
      if (cmd.sum) begin
         num_ff <= sum_type'(p_num_a_ff) - sum_type'(p_num_b_ff);
         den_ff <= sum_type'(p_den_a_ff) - sum_type'(p_den_b_ff);
         nt_ff  <= sum_type'(p_nt_a_ff) - sum_type'(p_nt_b_ff);
         nu_ff  <= sum_type'(p_nu_a_ff) - sum_type'(p_nu_b_ff);
      end
   end

   always_comb begin
      den_abs  = den_ff[SUM_W-1] ? -den_ff : den_ff;
      nt_adj   = den_ff[SUM_W-1] ? -nt_ff : nt_ff;
      nu_adj   = den_ff[SUM_W-1] ? -nu_ff : nu_ff;
      hit      = (den_ff != '0) && !nt_adj[SUM_W-1] && (nt_adj <= den_abs)
                 && !nu_adj[SUM_W-1] && (nu_adj <= den_abs);
      crossing = ((wz1_ff < 0 && wz2_ff > 0) || (wz1_ff > 0 && wz2_ff < 0))
                 && (num_ff != '0) && ((num_ff > 0) == (dz_ff > 0));
      rem_init = REM_W'($unsigned(nt_adj));
      rem_sh   = {rem_ff[REM_W-2:0], 1'b0};
   end

   assign sts.hit      = hit;
   assign sts.rsp_hold = rsp_valid_ff && !rsp_ready;

   // restoring divider, one quotient bit per cycle
   always_ff @(posedge clock) begin
      if (cmd.div_load) begin
         dvs_ff <= $unsigned(den_abs);
         if (rem_init >= REM_W'($unsigned(den_abs))) begin
            rem_ff <= rem_init - REM_W'($unsigned(den_abs));
            quo_ff <= QUO_W'(1);
         end else begin
            rem_ff <= rem_init;
            quo_ff <= '0;
         end
      end else if (cmd.div_step) begin
         if (rem_sh >= REM_W'(dvs_ff)) begin
            rem_ff <= rem_sh - REM_W'(dvs_ff);
            quo_ff <= {quo_ff[QUO_W-2:0], 1'b1};
         end else begin
            rem_ff <= rem_sh;
            quo_ff <= {quo_ff[QUO_W-2:0], 1'b0};
         end
      end
   end

   // running result and output register
   always_ff @(posedge clock) begin
      if (cmd.start) begin
         parity_ff    <= 1'b0;
         best_edge_ff <= '0;
         best_frac_ff <= FRAC_NONE;
      end else begin
         if (cmd.eval && crossing) begin
            parity_ff <= !parity_ff;
         end
         if (cmd.update && (18'(quo_ff) < best_frac_ff)) begin
            best_frac_ff <= 18'(quo_ff);
            best_edge_ff <= 9'({1'b0, cmd.edge_addr} + CNT_W'(1));
         end
      end
      if (cmd.out_load) begin
         rsp_ff.point_inside <= parity_ff;
         rsp_ff.hit_edge     <= best_edge_ff;
         rsp_ff.hit_fraction <= best_frac_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ----- rtl/core/polygon_wall_inside_and_hit_top.sv -----
// polygon_wall_inside_and_hit_top: top level of the polygon wall block
// depends on pwih_pkg, pwih_ctrl and pwih_datapath
//
// the block keeps a closed polygon of up to 256 wall vertices (Q11.12 r,z) and answers
// segment queries with an odd-crossing inside test of the start point and the nearest
// crossed wall edge (1-based, 0 for none) with its Q2.16 fraction (2.0 for none); a load
// item writes one vertex and gives no result; a query walks the edges one at a time
// through a five-stage fetch, difference, multiply, sum and check sequence, and an edge
// that is crossed adds a pass of the bit-serial fraction divider; csr_data sets the vertex
// count and is always ready; the user must write it only while the block is idle, which
// the block itself does not enforce; the finished result sits in an output register so
// the next item is taken while it waits
module polygon_wall_inside_and_hit_top (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  pwih_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output pwih_pkg::rsp_type rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [8:0]        csr_data
);
   import pwih_pkg::*;

   cmd_type cmd;
   sts_type sts;

   // register writes never stall
   assign csr_ready = 1'b1;

   // sequencer: edge counter, divider step count, handshake
   pwih_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_action (req_data.action),
      .req_index  (req_data.vertex_index),
      .csr_valid  (csr_valid),
      .csr_data   (csr_data),
      .sts        (sts),
      .cmd        (cmd)
   );

   // stores, arithmetic, divider and result register
   pwih_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .sts       (sts),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

`ifndef ASSERT_OFF
   // a query holds off the input until its result is built
   a_query_blocks: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_data.action == ACT_QUERY) |=> !req_ready)
      else $error("input taken while a query is in progress");

   // no edge goes with the no-hit fraction and the other way round
   a_hit_consistent: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_data.hit_edge == '0) == (rsp_data.hit_fraction == FRAC_NONE)))
      else $error("hit edge and fraction disagree");

   // a load item never makes a result
   a_load_silent: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_data.action == ACT_LOAD && !rsp_valid) |=> !rsp_valid)
      else $error("result after a load item");
`endif

endmodule
